// ----- src/at2_pkg.sv -----
// ----------------------------------------------------------------------------
// at2_pkg: shared types and constants of the four-quadrant arctangent block
// Fixed-point formats, polynomial coefficients and the pipeline structure
// shared by the preparation, divider, polynomial and output stages.
// ----------------------------------------------------------------------------
package at2_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_W       = SAMPLE_BITS;
   localparam int FRAC_BITS   = 16;
   localparam int Q_W         = FRAC_BITS + 1;
   localparam int DIV_STAGES  = Q_W;

   localparam int SLOPE_W     = 13;
   localparam int T_W         = 15;
   localparam int U_W         = 15;
   localparam int M_W         = 17;
   localparam int SLOPE_P_W   = SLOPE_W + Q_W;
   localparam int U_P_W       = Q_W + T_W;
   localparam int M_P_W       = Q_W + M_W;
   localparam int RES_W       = 20;
   localparam int ZMAG_W      = RES_W;
   localparam int SCALE_W     = 32;
   localparam int SCALE_P_W   = ZMAG_W + SCALE_W;
   localparam int MDEG_W      = ZMAG_W;
   localparam int ANGLE_W     = 19;

   localparam int PREP_STAGES = 2;
   localparam int POLY_STAGES = 3;
   localparam int POST_STAGES = 4;
   localparam int NUM_STAGES  = PREP_STAGES + DIV_STAGES + POLY_STAGES + POST_STAGES;

   localparam logic [Q_W-1:0]            Q_ONE        = Q_W'(1) << FRAC_BITS;
   localparam logic [M_W-1:0]            C_QUARTER_PI = M_W'(51472);
   localparam logic [T_W-1:0]            C_LIN        = T_W'(16037);
   localparam logic [SLOPE_W-1:0]        C_SLOPE      = SLOPE_W'(4345);
   localparam logic signed [RES_W-1:0]   HALF_PI_Q    = RES_W'(102944);
   localparam logic signed [RES_W-1:0]   PI_Q         = RES_W'(205887);
   localparam logic [SCALE_W-1:0]        MDEG_SCALE   = SCALE_W'(64'd3754936207);
   localparam logic [MDEG_W-1:0]         MDEG_MAX     = MDEG_W'(180000);
   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = ANGLE_W'(180000);

   typedef enum logic [1:0] {
      QUAD_I,
      QUAD_II,
      QUAD_III,
      QUAD_IV
   } quad_type;

   typedef struct packed {
      logic     swap;
      logic     flip;
      logic     both_zero;
      quad_type quad;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] den;
      logic [Q_W-1:0]   quo;
      side_type         side;
   } div_type;

   typedef struct packed {
      logic [M_W-1:0] m;
      side_type       side;
   } poly_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      both_zero;
   } result_type;

endpackage

// ----- src/at2_prep.sv -----
// ----------------------------------------------------------------------------
// at2_prep: sample preparation
// Splits both samples into sign and magnitude, then orders the magnitudes
// and classifies the quadrant for the divider.
// ----------------------------------------------------------------------------
module at2_prep import at2_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pipe_en,
   input  logic                          in_valid,
   input  logic signed [SAMPLE_BITS-1:0] y_value,
   input  logic signed [SAMPLE_BITS-1:0] x_value,
   output logic                          out_valid,
   output div_type                       out_div
);

   logic [MAG_W-1:0] y_raw;
   logic [MAG_W-1:0] x_raw;
   logic [MAG_W-1:0] ym_in, ym_ff;
   logic [MAG_W-1:0] xm_in, xm_ff;
   logic             yn_ff, xn_ff;
   logic             s1_valid_ff, s2_valid_ff;
   div_type          div_in, div_ff;
   logic             y_le, y_ge, x_le, x_ge;
   logic             swap;

   assign y_raw = y_value;
   assign x_raw = x_value;
   assign ym_in = y_raw[MAG_W-1] ? (~y_raw) + MAG_W'(1) : y_raw;
   assign xm_in = x_raw[MAG_W-1] ? (~x_raw) + MAG_W'(1) : x_raw;

   always_comb begin
      swap = ym_ff > xm_ff;
      y_ge = !yn_ff;
      y_le = yn_ff || (ym_ff == '0);
      x_ge = !xn_ff;
      x_le = xn_ff || (xm_ff == '0);
      div_in.rem = swap ? xm_ff : ym_ff;
      div_in.den = swap ? ym_ff : xm_ff;
      div_in.quo = '0;
      div_in.side.swap = swap;
      div_in.side.flip = (div_in.rem != '0) && (yn_ff != xn_ff);
      div_in.side.both_zero = (ym_ff == '0) && (xm_ff == '0);
      priority if (y_le && x_ge) begin
         div_in.side.quad = QUAD_IV;
      end else if (y_le && x_le) begin
         div_in.side.quad = QUAD_III;
      end else if (y_ge && x_le) begin
         div_in.side.quad = QUAD_II;
      end else begin
         div_in.side.quad = QUAD_I;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ym_ff  <= ym_in;
         xm_ff  <= xm_in;
         yn_ff  <= y_raw[MAG_W-1];
         xn_ff  <= x_raw[MAG_W-1];
         div_ff <= div_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_div   = div_ff;

endmodule

// ----- src/at2_div.sv -----
// ----------------------------------------------------------------------------
// at2_div: pipelined ratio divider
// Restoring division of the smaller magnitude by the larger, one quotient
// bit per stage, giving the Q1.16 ratio with 1.0 represented exactly.
// ----------------------------------------------------------------------------
module at2_div import at2_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pipe_en,
   input  logic    in_valid,
   input  div_type in_div,
   output logic    out_valid,
   output div_type out_div
);

   div_type                 stage_ff [DIV_STAGES];
   div_type                 stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]   valid_ff;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      div_type          prev;
      logic [MAG_W-1:0] shifted;
      logic             ge;

      if (k == 0) begin : g_first
         assign prev    = in_div;
         assign shifted = in_div.rem;
      end else begin : g_next
         assign prev    = stage_ff[k-1];
         assign shifted = {stage_ff[k-1].rem[MAG_W-2:0], 1'b0};
      end

      always_comb begin
         ge                = shifted >= prev.den;
         stage_in[k].rem   = ge ? shifted - prev.den : shifted;
         stage_in[k].den   = prev.den;
         stage_in[k].quo   = {prev.quo[Q_W-2:0], ge};
         stage_in[k].side  = prev.side;
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_div   = stage_ff[DIV_STAGES-1];

endmodule

// ----- src/at2_poly.sv -----
// ----------------------------------------------------------------------------
// at2_poly: cubic arctangent approximation
// Evaluates the polynomial on the Q1.16 ratio in three multiply stages, flooring after
// each product.
// ----------------------------------------------------------------------------
module at2_poly import at2_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pipe_en,
   input  logic     in_valid,
   input  div_type  in_div,
   output logic     out_valid,
   output poly_type out_poly
);

   logic [SLOPE_P_W-1:0] p_slope;
   logic [U_P_W-1:0]     p_u;
   logic [M_P_W-1:0]     p_m;
   logic [Q_W-1:0]       one_minus;
   logic [M_W-1:0]       coef_sum;

   logic [Q_W-1:0]       a_a_ff, a_b_ff;
   logic [T_W-1:0]       t_in, t_ff;
   logic [U_W-1:0]       u_in, u_ff;
   side_type             side_a_ff, side_b_ff;
   poly_type             poly_in, poly_ff;
   logic [2:0]           valid_ff;

   always_comb begin
      p_slope   = SLOPE_P_W'(in_div.quo) * SLOPE_P_W'(C_SLOPE);
      t_in      = C_LIN + T_W'(p_slope[SLOPE_P_W-1:FRAC_BITS]);
      one_minus = Q_ONE - a_a_ff;
      p_u       = U_P_W'(one_minus) * U_P_W'(t_ff);
      u_in      = U_W'(p_u[U_P_W-1:FRAC_BITS]);
      coef_sum  = C_QUARTER_PI + M_W'(u_ff);
      p_m       = M_P_W'(a_b_ff) * M_P_W'(coef_sum);
      poly_in.m    = M_W'(p_m[M_P_W-1:FRAC_BITS]);
      poly_in.side = side_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_a_ff    <= in_div.quo;
         t_ff      <= t_in;
         side_a_ff <= in_div.side;
         a_b_ff    <= a_a_ff;
         u_ff      <= u_in;
         side_b_ff <= side_a_ff;
         poly_ff   <= poly_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_poly  = poly_ff;

endmodule

// ----- src/at2_post.sv -----
// ----------------------------------------------------------------------------
// at2_post: angle correction and scaling
// Applies the octant and quadrant corrections, converts radians to
// millidegrees with truncation toward zero and saturates the result.
// ----------------------------------------------------------------------------
module at2_post import at2_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pipe_en,
   input  logic       in_valid,
   input  poly_type   in_poly,
   output logic       out_valid,
   output result_type out_result
);

   logic signed [RES_W-1:0] base;
   logic signed [RES_W-1:0] m_ext;
   logic signed [RES_W-1:0] res_in, res_ff;
   logic [ZMAG_W-1:0]       zmag_in, zmag_ff;
   logic [SCALE_P_W-1:0]    p_scale;
   logic [MDEG_W-1:0]       mdeg_in, mdeg_ff;
   logic [MDEG_W-1:0]       clamped;
   logic [ANGLE_W-1:0]      mag;
   logic                    neg_e_ff, neg_f_ff;
   logic                    bz_d_ff, bz_e_ff, bz_f_ff;
   result_type              result_in, result_ff;
   logic [POST_STAGES-1:0]  valid_ff;

   always_comb begin
      if (in_poly.side.swap) begin
         base = (in_poly.side.quad == QUAD_I || in_poly.side.quad == QUAD_II)
                ? HALF_PI_Q : -HALF_PI_Q;
      end else begin
         unique case (in_poly.side.quad)
            QUAD_II:  base = PI_Q;
            QUAD_III: base = -PI_Q;
            QUAD_I:   base = '0;
            QUAD_IV:  base = '0;
            default:  base = '0;
         endcase
      end
      m_ext  = $signed(RES_W'(in_poly.m));
      res_in = (in_poly.side.flip ^ in_poly.side.swap) ? base - m_ext : base + m_ext;

      zmag_in = res_ff[RES_W-1] ? ZMAG_W'(-res_ff) : ZMAG_W'(res_ff);

      p_scale = SCALE_P_W'(zmag_ff) * SCALE_P_W'(MDEG_SCALE);
      mdeg_in = MDEG_W'(p_scale[SCALE_P_W-1:SCALE_W]);

      clamped = (mdeg_ff > MDEG_MAX) ? MDEG_MAX : mdeg_ff;
      mag     = ANGLE_W'(clamped);
      if (bz_f_ff) begin
         result_in.angle = '0;
      end else begin
         result_in.angle = neg_f_ff ? $signed(-mag) : $signed(mag);
      end
      result_in.both_zero = bz_f_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[POST_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff    <= res_in;
         bz_d_ff   <= in_poly.side.both_zero;
         zmag_ff   <= zmag_in;
         neg_e_ff  <= res_ff[RES_W-1];
         bz_e_ff   <= bz_d_ff;
         mdeg_ff   <= mdeg_in;
         neg_f_ff  <= neg_e_ff;
         bz_f_ff   <= bz_e_ff;
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff[POST_STAGES-1];
   assign out_result = result_ff;

endmodule

// ----- src/atan2_polynomial_approx_millideg_top.sv -----
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_millideg_top: four-quadrant arctangent in millidegrees
// A request carries a signed (y, x) sample pair on req_y_value and
// req_x_value. Each request produces exactly one response: the angle of the
// vector in thousandths of a degree on rsp_angle_mdeg, truncated toward zero
// and within -180000..180000, plus rsp_both_zero, set when both samples are
// zero, in which case the angle is zero.
// Both channels use valid/ready handshakes. A new request is accepted every
// cycle while req_ready is high. Each request passes through two preparation
// stages, seventeen divider stages (one quotient bit each), three polynomial
// multiply stages, four correction and scaling stages and the output register.
// The divider's one-bit-per-stage subtract sets the depth; throughput is one
// request per cycle while req_ready is high.
// When the receiver stalls, one more result is caught in a skid register and
// then req_ready drops until the skid register drains; nothing is lost or
// repeated. Reset empties the pipeline and the output registers.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_millideg_top import at2_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_y_value,
   input  logic signed [SAMPLE_BITS-1:0] req_x_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ANGLE_W-1:0]     rsp_angle_mdeg,
   output logic                          rsp_both_zero
);

   logic       pipe_en;
   logic       prep_valid, div_valid, poly_valid, last_valid;
   div_type    prep_div, div_out;
   poly_type   poly_out;
   result_type last_result;

   logic       out_valid_in, out_valid_ff;
   logic       skid_valid_in, skid_valid_ff;
   result_type out_in, out_ff;
   result_type skid_in, skid_ff;

   assign pipe_en   = !skid_valid_ff;
   assign req_ready = pipe_en;

   at2_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_valid),
      .y_value   (req_y_value),
      .x_value   (req_x_value),
      .out_valid (prep_valid),
      .out_div   (prep_div)
   );

   at2_div u_div (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (prep_valid),
      .in_div    (prep_div),
      .out_valid (div_valid),
      .out_div   (div_out)
   );

   at2_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (div_valid),
      .in_div    (div_out),
      .out_valid (poly_valid),
      .out_poly  (poly_out)
   );

   at2_post u_post (
      .clock      (clock),
      .reset      (reset),
      .pipe_en    (pipe_en),
      .in_valid   (poly_valid),
      .in_poly    (poly_out),
      .out_valid  (last_valid),
      .out_result (last_result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = last_result;
            out_valid_in = pipe_en && last_valid;
         end
      end else if (pipe_en && last_valid) begin
         skid_in       = last_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_angle_mdeg = out_ff.angle;
   assign rsp_both_zero  = out_ff.both_zero;

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_both_zero |-> rsp_angle_mdeg == '0)
      else $error("Zero vector response carries a nonzero angle.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_mdeg <= ANGLE_LIMIT && rsp_angle_mdeg >= -ANGLE_LIMIT)
      else $error("Response angle is outside the half-turn range.");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a result while the output register is empty.");

   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready && !skid_valid_ff && last_valid |=> skid_valid_ff)
      else $error("A result leaving the pipeline during a stall was not captured.");

endmodule

// ----- bench/atan2_polynomial_approx_millideg_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_millideg_top_tb: self-checking bench for the arctangent
// Sends signed (y, x) sample pairs through the valid/ready request channel,
// predicts each angle in millidegrees with a fixed-point model of its own and
// compares every response field by field, in order. Directed pairs cover the
// axes, the diagonals, both-zero and the most negative samples; random pairs
// follow, with random idle gaps on both sides, two long receiver hold-offs that
// back up the pipeline and sender pauses that let the pipeline run empty.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_millideg_top_tb import at2_pkg::*;;

   localparam longint unsigned RATIO_ONE      = 65536;
   localparam longint unsigned QUARTER_PI_Q16 = 51472;
   localparam longint unsigned POLY_LIN       = 16037;
   localparam longint unsigned POLY_SLOPE     = 4345;
   localparam longint          HALF_PI_Q16    = 102944;
   localparam longint          PI_Q16         = 205887;
   localparam longint unsigned MDEG_SCALE_Q32 = 64'd3754936207;
   localparam longint unsigned ANGLE_FULL     = 180000;
   localparam int              RANDOM_PAIRS   = 950;
   localparam int              LONG_HOLD      = 250;
   localparam int              TAIL_CYCLES    = 40;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] y;
      logic signed [SAMPLE_BITS-1:0] x;
      int unsigned                   gap;
      bit                            drain_first;
   } pair_req_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] y;
      logic signed [SAMPLE_BITS-1:0] x;
      result_type                    res;
   } angle_check_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_y_value = '0;
   logic signed [SAMPLE_BITS-1:0] req_x_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [ANGLE_W-1:0]     rsp_angle_mdeg;
   logic                          rsp_both_zero;

   pair_req_type    pending_pairs[$];
   angle_check_type angle_expected[$];
   int unsigned     sent_count = 0;
   int unsigned     rsp_count = 0;
   int unsigned     zero_count = 0;
   int unsigned     hold_cycles = 0;
   int unsigned     mismatch_count = 0;

   atan2_polynomial_approx_millideg_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_y_value    (req_y_value),
      .req_x_value    (req_x_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_angle_mdeg (rsp_angle_mdeg),
      .rsp_both_zero  (rsp_both_zero)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type atan2_mdeg(logic signed [SAMPLE_BITS-1:0] y,
                                             logic signed [SAMPLE_BITS-1:0] x);
      logic [SAMPLE_BITS:0] y_mag, x_mag, num, den;
      logic                 y_neg, x_neg, swapped, ratio_neg;
      logic                 y_le, y_ge, x_le, x_ge;
      longint unsigned      ratio, t, u, m, mag, mdeg;
      longint               z, angle;
      quad_type             quad;
      result_type           r;
      y_neg = y[SAMPLE_BITS-1];
      x_neg = x[SAMPLE_BITS-1];
      y_mag = y_neg ? (SAMPLE_BITS+1)'(-int'(y)) : (SAMPLE_BITS+1)'(int'(y));
      x_mag = x_neg ? (SAMPLE_BITS+1)'(-int'(x)) : (SAMPLE_BITS+1)'(int'(x));
      if (y_mag == 0 && x_mag == 0) begin
         r.angle = '0;
         r.both_zero = 1'b1;
         return r;
      end
      swapped = y_mag > x_mag;
      num = swapped ? x_mag : y_mag;
      den = swapped ? y_mag : x_mag;
      ratio = (longint'(num) << 16) / longint'(den);
      if (ratio > RATIO_ONE) ratio = RATIO_ONE;
      ratio_neg = (num != 0) && (y_neg != x_neg);

      t = POLY_LIN + ((POLY_SLOPE * ratio) >> 16);
      u = ((RATIO_ONE - ratio) * t) >> 16;
      m = (ratio * (QUARTER_PI_Q16 + u)) >> 16;
      z = ratio_neg ? -longint'(m) : longint'(m);

      y_ge = !y_neg;
      y_le = y_neg || y_mag == 0;
      x_ge = !x_neg;
      x_le = x_neg || x_mag == 0;
      if (y_le && x_ge) quad = QUAD_IV;
      else if (y_le && x_le) quad = QUAD_III;
      else if (y_ge && x_le) quad = QUAD_II;
      else quad = QUAD_I;

      if (swapped) begin
         angle = (quad == QUAD_I || quad == QUAD_II) ? HALF_PI_Q16 - z : -HALF_PI_Q16 - z;
      end else if (quad == QUAD_II) begin
         angle = PI_Q16 + z;
      end else if (quad == QUAD_III) begin
         angle = -PI_Q16 + z;
      end else begin
         angle = z;
      end

      mag = (angle < 0) ? longint'(-angle) : longint'(angle);
      mdeg = (mag * MDEG_SCALE_Q32) >> 32;
      if (mdeg > ANGLE_FULL) mdeg = ANGLE_FULL;
      r.angle = (angle < 0) ? ANGLE_W'(-longint'(mdeg)) : ANGLE_W'(mdeg);
      r.both_zero = 1'b0;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic log_mismatch(input string what);
      mismatch_count++;
      $display("%0t ERROR %s", $time, what);
   endtask

   task automatic add_pair(input int y, input int x, input int unsigned gap,
                           input bit drain_first);
      pair_req_type p;
      p.y = SAMPLE_BITS'(y);
      p.x = SAMPLE_BITS'(x);
      p.gap = gap;
      p.drain_first = drain_first;
      pending_pairs.push_back(p);
   endtask

   always @(posedge clock) begin : request_driver
      logic            next_valid;
      bit              gap_armed;
      int unsigned     idle_left;
      angle_check_type entry;
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
         idle_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            entry.y = req_y_value;
            entry.x = req_x_value;
            entry.res = atan2_mdeg(req_y_value, req_x_value);
            angle_expected.push_back(entry);
            sent_count++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_pairs.size() > 0) begin
            if (!gap_armed) begin
               idle_left = pending_pairs[0].gap;
               gap_armed = 1'b1;
            end
            if (idle_left > 0) begin
               idle_left--;
            end else if (!(pending_pairs[0].drain_first && angle_expected.size() > 0)) begin
               req_y_value <= pending_pairs[0].y;
               req_x_value <= pending_pairs[0].x;
               void'(pending_pairs.pop_front());
               next_valid = 1'b1;
               gap_armed = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   always @(posedge clock) begin : response_monitor
      logic            ready_next;
      int unsigned     hold_left;
      int unsigned     stall_left;
      angle_check_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (angle_expected.size() == 0) begin
               log_mismatch($sformatf("response angle %0d with no request outstanding",
                                      rsp_angle_mdeg));
            end else begin
               want = angle_expected.pop_front();
               if (want.res.both_zero) zero_count++;
               if (rsp_angle_mdeg !== want.res.angle)
                  log_mismatch($sformatf("y=%0d x=%0d angle %0d, predicted %0d",
                                         want.y, want.x, rsp_angle_mdeg, want.res.angle));
               if (rsp_both_zero !== want.res.both_zero)
                  log_mismatch($sformatf("y=%0d x=%0d both_zero %0b, predicted %0b",
                                         want.y, want.x, rsp_both_zero,
                                         want.res.both_zero));
            end
            if (rsp_count == 120 || rsp_count == 600) hold_left = LONG_HOLD;
         end
         ready_next = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            hold_cycles++;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if ((rsp_count / 150) % 3 != 1 && $urandom_range(0, 4) == 0) begin
            stall_left = idle_length() - 1;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin : stimulus
      int          y, x, kind;
      int unsigned gap;
      int          corner[6];
      corner = '{-32768, -32767, -1, 0, 1, 32767};

      add_pair(0, 0, 0, 1'b0);
      add_pair(0, -32768, 0, 1'b0);
      add_pair(0, -1, 0, 1'b0);
      add_pair(0, 32767, 0, 1'b0);
      add_pair(0, 1, 0, 1'b0);
      add_pair(32767, 0, 0, 1'b0);
      add_pair(-32768, 0, 0, 1'b0);
      add_pair(1, 0, 0, 1'b0);
      add_pair(-1, 0, 0, 1'b0);
      add_pair(-32768, -32768, 0, 1'b0);
      add_pair(-32768, 32767, 0, 1'b0);
      add_pair(32767, -32768, 0, 1'b0);
      add_pair(32767, 32767, 0, 1'b0);
      add_pair(1, 1, 0, 1'b0);
      add_pair(-1, -1, 0, 1'b0);
      add_pair(1, -1, 0, 1'b0);
      add_pair(-1, 1, 0, 1'b0);
      add_pair(100, -32768, 0, 1'b0);
      add_pair(-32768, 100, 0, 1'b0);
      add_pair(12345, -23456, 0, 1'b0);
      add_pair(-20000, -10000, 0, 1'b0);
      add_pair(21845, -21846, 0, 1'b0);
      add_pair(0, 0, 0, 1'b0);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         kind = $urandom_range(0, 9);
         y = $signed(SAMPLE_BITS'($urandom()));
         x = $signed(SAMPLE_BITS'($urandom()));
         unique case (kind)
            5: begin
               y = $urandom_range(0, 8) - 4;
               x = $urandom_range(0, 8) - 4;
            end
            6: if ($urandom_range(0, 1) == 0) y = 0; else x = 0;
            7: x = ($urandom_range(0, 1) == 0) ? y : -y;
            8: begin
               y = corner[$urandom_range(0, 5)];
               x = corner[$urandom_range(0, 5)];
            end
            9: x = y + $urandom_range(0, 6) - 3;
            default: ;
         endcase
         if ((i / 150) % 3 == 2 || $urandom_range(0, 2) != 0) gap = 0;
         else gap = idle_length();
         add_pair(y, x, gap, i == 0 || i == 400 || i == 800);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() > 0 || req_valid) @(posedge clock);
      while (angle_expected.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d responses to %0d requests, %0d of them with both samples zero.",
               rsp_count, sent_count, zero_count);
      $display("Receiver held off for %0d cycles in long stretches; %0d mismatches.",
               hold_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #6_000_000;
      $display("Timeout with %0d responses still outstanding.", angle_expected.size());
      $display("simulation failed");
      $finish;
   end

endmodule
